// ----- rtl/sql2_pkg.sv -----
package sql2_pkg;

	localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
	localparam logic [7:0]  EXP_MAX   = 8'hFF;

	function automatic logic is_nan(input logic [31:0] x);
		return (x[30:23] == EXP_MAX) && (x[22:0] != 23'd0);
	endfunction

	function automatic logic is_inf(input logic [31:0] x);
		return (x[30:23] == EXP_MAX) && (x[22:0] == 23'd0);
	endfunction

	function automatic logic [4:0] clz27(input logic [26:0] v);
		logic [4:0] n;
		logic       found;
		n = 5'd27;
		found = 1'b0;
		for (int i = 26; i >= 0; i--) begin
			if (!found && v[i]) begin
				n = 5'(26 - i);
				found = 1'b1;
			end
		end
		return n;
	endfunction

	function automatic logic [5:0] clz48(input logic [47:0] v);
		logic [5:0] n;
		logic       found;
		n = 6'd48;
		found = 1'b0;
		for (int i = 47; i >= 0; i--) begin
			if (!found && v[i]) begin
				n = 6'(47 - i);
				found = 1'b1;
			end
		end
		return n;
	endfunction

	// Round to nearest even and pack. ex is at least 1; a result whose hidden
	// bit stays clear after rounding is subnormal and gets a zero exponent.
	function automatic logic [31:0] round_pack(input logic sgn, input logic [10:0] ex,
			input logic [23:0] m, input logic g, input logic st);
		logic        inc;
		logic [24:0] r;
		logic [10:0] e;
		logic [22:0] frac;
		inc = g & (st | m[0]);
		r = {1'b0, m} + {24'd0, inc};
		if (r[24]) begin
			e = ex + 11'd1;
			frac = 23'd0;
		end else begin
			e = r[23] ? ex : 11'd0;
			frac = r[22:0];
		end
		if (e >= 11'd255)
			return {sgn, EXP_MAX, 23'd0};
		return {sgn, e[7:0], frac};
	endfunction

	function automatic logic [31:0] fp_add(input logic [31:0] x, input logic [31:0] y);
		logic [31:0] big;
		logic [31:0] sml;
		logic [7:0]  eb;
		logic [7:0]  es;
		logic [26:0] mb;
		logic [26:0] ms;
		logic [26:0] mal;
		logic [26:0] mask;
		logic [7:0]  d;
		logic        stk;
		logic        sub;
		logic [27:0] sm;
		logic [26:0] m;
		logic [9:0]  ex;
		logic [4:0]  lz;
		logic [4:0]  sh;
		logic [31:0] res;
		if (is_nan(x) || is_nan(y)) begin
			res = CANON_NAN;
		end else if (is_inf(x) && is_inf(y) && (x[31] != y[31])) begin
			res = CANON_NAN;
		end else if (is_inf(x)) begin
			res = x;
		end else if (is_inf(y)) begin
			res = y;
		end else begin
			if (x[30:0] >= y[30:0]) begin
				big = x;
				sml = y;
			end else begin
				big = y;
				sml = x;
			end
			eb = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
			es = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
			mb = {big[30:23] != 8'd0, big[22:0], 3'b000};
			ms = {sml[30:23] != 8'd0, sml[22:0], 3'b000};
			d = eb - es;
			if (d >= 8'd27) begin
				mal = 27'd0;
				stk = |ms;
			end else begin
				mask = ~({27{1'b1}} << d);
				stk = |(ms & mask);
				mal = ms >> d;
			end
			mal = mal | {26'd0, stk};
			sub = big[31] ^ sml[31];
			sm = sub ? ({1'b0, mb} - {1'b0, mal}) : ({1'b0, mb} + {1'b0, mal});
			ex = {2'b00, eb};
			if (sm == 28'd0) begin
				res = {sub ? 1'b0 : big[31], 31'd0};
			end else if (sm[27]) begin
				m = {sm[27:2], sm[1] | sm[0]};
				ex = ex + 10'd1;
				res = round_pack(big[31], {1'b0, ex}, m[26:3], m[2], |m[1:0]);
			end else begin
				lz = clz27(sm[26:0]);
				sh = ({5'd0, lz} > (ex - 10'd1)) ? 5'(ex - 10'd1) : lz;
				m = sm[26:0] << sh;
				ex = ex - {5'd0, sh};
				res = round_pack(big[31], {1'b0, ex}, m[26:3], m[2], |m[1:0]);
			end
		end
		return res;
	endfunction

endpackage

// ----- rtl/squared_l2_distance_fp32_core.sv -----
// Squared Euclidean distance of two FP32 vectors, one element pair per request.
// Input channel: in_valid/in_ready with a_value, b_value and last_element.
// Output channel: out_valid/out_ready with distance, one per vector, sent for
// the request that carries last_element.
// Each pair goes through four register stages: input, difference, raw product,
// rounded square; the square is added into the running sum as it leaves the
// last stage, and the sum of a finished vector lands in the output register.
// A distance is valid once its last request has left the rounded-square stage.
// Throughput is one request per cycle outside the output stall described below;
// the accumulator loop (sum register through one FP32 adder) sets that figure.
// While a distance waits in the output register, requests keep flowing until a
// second last-of-vector request reaches the accumulator; only that request and
// the stages behind it hold.
// Reset clears all stage valids, the output valid and the sum to positive zero.
// All three operations round to nearest even, keep subnormals, and any NaN
// turns the sum into the quiet NaN 0x7FC00000 until the vector ends.
module squared_l2_distance_fp32_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] a_value,
	input  logic [31:0] b_value,
	input  logic        last_element,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] distance
);
	import sql2_pkg::*;

	logic        v_s1, v_s2, v_s3, v_s4;
	logic        last_s1, last_s2, last_s3, last_s4;
	logic [31:0] a_s1, b_s1;
	logic [31:0] diff_s2;
	logic [47:0] prod_s3;
	logic [8:0]  esum_s3;
	logic        nan_s3, inf_s3, zero_s3;
	logic [31:0] sq_s4;
	logic [31:0] sum_q;
	logic        out_valid_q;
	logic [31:0] distance_q;

	logic        consume4, rdy4, rdy3, rdy2;
	logic [31:0] diff_c;
	logic [7:0]  ed;
	logic [23:0] md;
	logic [31:0] sq_c;
	logic [31:0] acc_c;

	assign consume4 = v_s4 && (!last_s4 || !out_valid_q || out_ready);
	assign rdy4     = !v_s4 || consume4;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign in_ready = !v_s1 || rdy2;

	assign out_valid = out_valid_q;
	assign distance  = distance_q;

	// a - b is an addition with the sign of b flipped.
	assign diff_c = fp_add(a_s1, {~b_s1[31], b_s1[30:0]});
	assign ed     = (diff_s2[30:23] == 8'd0) ? 8'd1 : diff_s2[30:23];
	assign md     = {diff_s2[30:23] != 8'd0, diff_s2[22:0]};

	// Normalize and round the squared difference.
	always_comb begin
		logic [5:0]         lz;
		logic signed [11:0] e_sig;
		logic signed [11:0] rsh;
		logic [47:0]        n;
		logic [47:0]        nd;
		logic [47:0]        mask;
		logic               st;
		logic [10:0]        ex;
		lz = clz48(prod_s3);
		e_sig = $signed({3'b000, esum_s3}) - 12'sd126 - $signed({6'd0, lz});
		n = prod_s3 << lz;
		rsh = 12'sd1 - e_sig;
		st = 1'b0;
		nd = n;
		mask = 48'd0;
		ex = e_sig[10:0];
		if (e_sig < 12'sd1) begin
			ex = 11'd1;
			if (rsh >= 12'sd48) begin
				nd = 48'd0;
				st = |n;
			end else begin
				mask = ~({48{1'b1}} << rsh[5:0]);
				st = |(n & mask);
				nd = n >> rsh[5:0];
			end
		end
		if (nan_s3)
			sq_c = CANON_NAN;
		else if (inf_s3)
			sq_c = {1'b0, EXP_MAX, 23'd0};
		else if (zero_s3)
			sq_c = 32'd0;
		else
			sq_c = round_pack(1'b0, ex, nd[47:24], nd[23], st | (|nd[22:0]));
	end

	assign acc_c = fp_add(sum_q, sq_s4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
			sum_q       <= 32'd0;
		end else begin
			if (in_ready)
				v_s1 <= in_valid;
			if (rdy2)
				v_s2 <= v_s1;
			if (rdy3)
				v_s3 <= v_s2;
			if (rdy4)
				v_s4 <= v_s3;
			if (consume4 && last_s4)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			if (consume4)
				sum_q <= last_s4 ? 32'd0 : acc_c;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			a_s1    <= a_value;
			b_s1    <= b_value;
			last_s1 <= last_element;
		end
		if (rdy2 && v_s1) begin
			diff_s2 <= diff_c;
			last_s2 <= last_s1;
		end
		if (rdy3 && v_s2) begin
			prod_s3 <= md * md;
			esum_s3 <= {1'b0, ed} + {1'b0, ed};
			nan_s3  <= is_nan(diff_s2);
			inf_s3  <= is_inf(diff_s2);
			zero_s3 <= diff_s2[30:0] == 31'd0;
			last_s3 <= last_s2;
		end
		if (rdy4 && v_s3) begin
			sq_s4   <= sq_c;
			last_s4 <= last_s3;
		end
		if (consume4 && last_s4)
			distance_q <= acc_c;
	end

endmodule
